### hw/rtl/mad_pkg.sv
package mad_pkg;

    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int CURVE_DEPTH      = 256;
    localparam int CURVE_IDX_W      = $clog2(CURVE_DEPTH);
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DRIVE     = 3'd0,
        REG_MIX       = 3'd1,
        REG_PRE_GAIN  = 3'd2,
        REG_POST_GAIN = 3'd3,
        REG_MODE      = 3'd4
    } cfg_reg_t;

    localparam logic [2:0] MODE_SOFT  = 3'd0;
    localparam logic [2:0] MODE_HARD  = 3'd1;
    localparam logic [2:0] MODE_FOLD  = 3'd2;
    localparam logic [2:0] MODE_WAVE  = 3'd3;
    localparam logic [2:0] MODE_CRUSH = 3'd4;

    // Curve nodes in Q.31, node CURVE_DEPTH included
    typedef logic [31:0] curve_tab_t [0:CURVE_DEPTH];

    localparam logic [63:0] Q31_ONE = 64'd1 << 31;

    // unsigned long division by shift and subtract, for table building only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(-f) for f in [0,1] Q.31, alternating series
    function automatic logic [63:0] exp_unit(input logic [63:0] f);
        logic [63:0] term;
        logic [63:0] sum;
        term = Q31_ONE;
        sum  = Q31_ONE;
        for (int k = 1; k <= 24; k++) begin
            term = ((term * f) >> 31) / 64'(k);
            if ((k & 1) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // exp(-t) for t in Q.31, t <= 16
    function automatic logic [63:0] exp_neg(input logic [63:0] t);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] e1;
        n  = t >> 31;
        r  = exp_unit(t & (Q31_ONE - 64'd1));
        e1 = exp_unit(Q31_ONE);
        for (int j = 0; j < 17; j++) begin
            if (64'(j) < n) begin
                r = (r * e1) >> 31;
            end
        end
        return r;
    endfunction

    function automatic curve_tab_t make_exp_tab();
        curve_tab_t tab;
        logic [63:0] e;
        for (int i = 0; i <= CURVE_DEPTH; i++) begin
            e      = exp_neg((64'(i) << 35) / CURVE_DEPTH);
            tab[i] = e[31:0];
        end
        return tab;
    endfunction

    function automatic curve_tab_t make_tanh_tab();
        curve_tab_t tab;
        logic [63:0] e;
        logic [63:0] t;
        for (int i = 0; i <= CURVE_DEPTH; i++) begin
            e      = exp_neg((64'(i) << 35) / CURVE_DEPTH);
            t      = udiv64((Q31_ONE - e) << 31, Q31_ONE + e);
            tab[i] = t[31:0];
        end
        return tab;
    endfunction

endpackage

### hw/rtl/mad_div.sv
module mad_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 16,
    parameter int QUO_W = 24
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [QUO_W-1:0] quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DEN_W:0]   trial;
    logic             qbit;

    // one restoring step: shift in the next numerator bit, subtract if it fits
    always_comb begin
        trial    = {rem_reg, num_reg[NUM_W-1]};
        qbit     = trial >= {1'b0, den_reg};
        rem_next = qbit ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        num_next = {num_reg[NUM_W-2:0], qbit};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign quo  = num_reg[QUO_W-1:0];

endmodule

### hw/rtl/multimode_audio_distortion_top.sv
// Ten register stages with per-stage valid bits carry an input transfer to the m_ side.
// Throughput: one sample per cycle, unless m_tready stalls or the thresholds are recomputed.
// After reset and after each drive_amount write, the fold threshold is recomputed
// by a bit-serial divider and s_tready stays low until the divider is done.
// Reset (aresetn, synchronous, active low) empties the pipeline and loads default registers.
module multimode_audio_distortion_top #(
    parameter int SAMPLE_WIDTH = mad_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mad_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mad_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_tdata,   // in_sample
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    m_tdata    // out_sample
);
    import mad_pkg::*;

    localparam int W     = SAMPLE_WIDTH;
    localparam int FRAC  = W - 1;
    localparam int TD_W  = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int XW    = W + 3;   // pre-gained sample
    localparam int YW    = W + 5;   // driven sample, signed
    localparam int AW    = W + 4;   // its magnitude
    localparam int UW    = W + 7;   // exp argument
    localparam int VW    = W + 5;   // mixed sample
    localparam int NSTG  = 10;
    localparam int IW    = CURVE_IDX_W;
    localparam int T_SH  = FRAC + 3;   // tanh spans [0,8)
    localparam int E_SH  = FRAC + 4;   // exp spans [0,16)
    localparam int FN_W  = FRAC + 13;
    localparam int H_SH  = FRAC - 13;  // 40960 = 5 * 2^13
    localparam int HF_1  = (1 << H_SH) / 5;
    localparam int HF_2  = (2 << H_SH) / 5;
    localparam int HF_3  = (3 << H_SH) / 5;
    localparam int HF_4  = (4 << H_SH) / 5;

    localparam curve_tab_t EXP_TAB  = make_exp_tab();
    localparam curve_tab_t TANH_TAB = make_tanh_tab();

    localparam logic signed [VW+2:0] SAT_HI = $signed((VW+3)'((longint'(1) << FRAC) - 1));
    localparam logic signed [VW+2:0] SAT_LO = ~SAT_HI;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [12:0] drive_reg, mix_reg;
    logic [13:0] pre_reg, post_reg;
    logic [2:0]  mode_reg;
    logic        cfg_fire;
    logic        start_reg;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_reg <= 13'd2048;
            mix_reg   <= 13'd2048;
            pre_reg   <= 14'd4096;
            post_reg  <= 14'd4096;
            mode_reg  <= MODE_SOFT;
        end else if (cfg_fire) begin
            unique case (cfg_index)
                REG_DRIVE:     drive_reg <= cfg_data[12:0];
                REG_MIX:       mix_reg   <= cfg_data[12:0];
                REG_PRE_GAIN:  pre_reg   <= cfg_data;
                REG_POST_GAIN: post_reg  <= cfg_data;
                REG_MODE:      mode_reg  <= cfg_data[2:0];
                default: ;   // drop writes to unknown indexes
            endcase
        end
    end

    // Kick the threshold divider in the cycle after reset or a drive write,
    // so it sees the new drive value.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= 1'b1;
        end else begin
            start_reg <= cfg_fire && (cfg_index == REG_DRIVE);
        end
    end

    // Drive- and mix-derived coefficients; the user keeps them stable while samples flow (not enforced here)
    logic [12:0] d_eff, m_eff, m_inv;
    logic [14:0] k3, k5;
    logic [15:0] hard_base;
    logic [16:0] crush_num;
    logic [4:0]  crush_bits;
    logic [YW-1:0] crush_mask;

    always_comb begin
        d_eff      = (drive_reg > 13'd4096) ? 13'd4096 : drive_reg;
        m_eff      = (mix_reg > 13'd4096) ? 13'd4096 : mix_reg;
        m_inv      = 13'd4096 - m_eff;
        k3         = 15'd4096 + 15'(d_eff) * 15'd3;
        k5         = 15'd4096 + 15'(d_eff) * 15'd5;
        hard_base  = 16'd40960 - 16'(d_eff) * 16'd9;
        crush_num  = 17'd65536 - 17'(d_eff) * 17'd14;
        crush_bits = crush_num[16:12];
        // keep bit j when j >= FRAC - bits
        for (int j = 0; j < YW; j++) begin
            crush_mask[j] = (j + int'(crush_bits)) >= FRAC;
        end
    end

    // ---------------------------------------------------------------
    // Thresholds: hard clip (1-0.9d) and fold 1/(1+3d), in Q.FRAC
    // ---------------------------------------------------------------
    logic [W-1:0] thr_h, thr_f;
    logic         fdiv_busy, thr_busy;
    logic [31:0]  hb_prod;
    logic [13:0]  hb_q;
    logic [2:0]   hb_r;
    logic [W-1:0] hb_frac;

    // Hard threshold is hard_base * 2^FRAC / 40960: divide by five with a
    // reciprocal multiply (exact for 16-bit operands), then fill the low
    // bits from the remainder.
    always_comb begin
        hb_prod = 32'(hard_base) * 32'd52429;
        hb_q    = hb_prod[31:18];
        hb_r    = 3'(hard_base - 16'(hb_q) * 16'd5);
        case (hb_r)
            3'd1:    hb_frac = W'(HF_1);
            3'd2:    hb_frac = W'(HF_2);
            3'd3:    hb_frac = W'(HF_3);
            3'd4:    hb_frac = W'(HF_4);
            default: hb_frac = '0;
        endcase
        thr_h = (W'(hb_q) << H_SH) + hb_frac;
    end

    mad_div #(.NUM_W(FN_W), .DEN_W(15), .QUO_W(W)) u_fold_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .num     ({1'b1, {(FRAC+12){1'b0}}}),
        .den     (k3),
        .busy    (fdiv_busy),
        .quo     (thr_f)
    );

    assign thr_busy = start_reg || fdiv_busy;

    // ---------------------------------------------------------------
    // Pipeline flow control: a stage advances when empty or when the
    // stage after it advances.
    // ---------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG:0]   adv;
    logic            in_fire;

    always_comb begin
        adv[NSTG] = m_tready;
        for (int i = NSTG - 1; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign s_tready = adv[0] && !thr_busy;
    assign in_fire  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= in_fire;
            end
            for (int i = 1; i < NSTG; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // restoring step of the fold quotient: returns {quotient bit, remainder}
    function automatic logic [AW:0] fold_step(input logic [AW-1:0] rem,
                                              input logic [W-1:0] thr, input int sh);
        logic [AW+6:0] div_sh;
        logic [AW+6:0] rem_w;
        div_sh = (AW+7)'(thr) << sh;
        rem_w  = (AW+7)'(rem);
        if (rem_w >= div_sh) begin
            return {1'b1, AW'(rem_w - div_sh)};
        end
        return {1'b0, rem};
    endfunction

    // ---------------------------------------------------------------
    // Stage 0: capture sample
    // ---------------------------------------------------------------
    logic signed [W-1:0] s0_dry_reg;
    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            s0_dry_reg <= $signed(s_tdata[W-1:0]);
        end
    end

    // Stage 1: input gain
    logic signed [W+14:0] x_prod;
    logic signed [W-1:0]  s1_dry_reg;
    logic signed [XW-1:0] s1_x_reg;
    assign x_prod = s0_dry_reg * $signed({1'b0, pre_reg});
    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            s1_dry_reg <= s0_dry_reg;
            s1_x_reg   <= x_prod[W+14:12];
        end
    end

    // Stage 2: drive gains 1+3d and 1+5d
    logic signed [XW+15:0] y3_prod, y5_prod;
    logic signed [W-1:0]   s2_dry_reg;
    logic signed [YW-1:0]  s2_y3_reg, s2_y5_reg;
    assign y3_prod = s1_x_reg * $signed({1'b0, k3});
    assign y5_prod = s1_x_reg * $signed({1'b0, k5});
    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            s2_dry_reg <= s1_dry_reg;
            s2_y3_reg  <= y3_prod[12 +: YW];
            s2_y5_reg  <= y5_prod[12 +: YW];
        end
    end

    // Stage 3: tanh node read, exp argument, clip, crush, fold steps 6..5
    logic signed [YW-1:0] y3_abs, y5_abs, hard_next, thr_h_s;
    logic [AW-1:0]        a3, a5;
    logic [AW+IW-1:0]     tpos;
    logic [IW-1:0]        t_idx;
    logic                 t_ov;
    logic [AW+14:0]       u_prod;
    logic [AW:0]          f3a, f3b;

    always_comb begin
        y3_abs  = s2_y3_reg[YW-1] ? -s2_y3_reg : s2_y3_reg;
        y5_abs  = s2_y5_reg[YW-1] ? -s2_y5_reg : s2_y5_reg;
        a3      = y3_abs[AW-1:0];
        a5      = y5_abs[AW-1:0];
        tpos    = {a3, {IW{1'b0}}};
        t_idx   = tpos[T_SH +: IW];
        t_ov    = |tpos[AW+IW-1:T_SH+IW];
        u_prod  = a5 * (AW+15)'(k3);
        thr_h_s = $signed(YW'(thr_h));
        if (s2_y5_reg > thr_h_s) begin
            hard_next = thr_h_s;
        end else if (s2_y5_reg < -thr_h_s) begin
            hard_next = -thr_h_s;
        end else begin
            hard_next = s2_y5_reg;
        end
        f3a = fold_step(a3, thr_f, 6);
        f3b = fold_step(f3a[AW-1:0], thr_f, 5);
    end

    logic signed [W-1:0]  s3_dry_reg;
    logic signed [YW-1:0] s3_y3_reg, s3_hard_reg, s3_crush_reg;
    logic                 s3_y3neg_reg, s3_y5pos_reg, s3_fsmall_reg;
    logic [31:0]          s3_t0_reg, s3_t1_reg;
    logic [15:0]          s3_tfr_reg;
    logic [UW-1:0]        s3_u_reg;
    logic [AW-1:0]        s3_frem_reg;

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            s3_dry_reg    <= s2_dry_reg;
            s3_y3_reg     <= s2_y3_reg;
            s3_y3neg_reg  <= s2_y3_reg[YW-1];
            s3_y5pos_reg  <= !s2_y5_reg[YW-1] && (s2_y5_reg != '0);
            s3_t0_reg     <= t_ov ? TANH_TAB[CURVE_DEPTH] : TANH_TAB[{1'b0, t_idx}];
            s3_t1_reg     <= t_ov ? TANH_TAB[CURVE_DEPTH]
                                  : TANH_TAB[{1'b0, t_idx} + (IW+1)'(1)];
            s3_tfr_reg    <= tpos[T_SH-1 -: 16];
            s3_u_reg      <= u_prod[12 +: UW];
            s3_hard_reg   <= hard_next;
            s3_crush_reg  <= s2_y3_reg & $signed(crush_mask);
            s3_frem_reg   <= f3b[AW-1:0];
            s3_fsmall_reg <= a3 <= AW'(thr_f);
        end
    end

    // Stage 4: tanh interpolation product, exp node read, fold steps 4..3
    logic signed [32:0]   t_diff;
    logic signed [49:0]   t_prod;
    logic [UW+IW-1:0]     epos;
    logic [IW-1:0]        e_idx;
    logic                 e_ov;
    logic [AW:0]          f4a, f4b;

    always_comb begin
        t_diff = $signed({1'b0, s3_t1_reg}) - $signed({1'b0, s3_t0_reg});
        t_prod = t_diff * $signed({1'b0, s3_tfr_reg});
        epos   = {s3_u_reg, {IW{1'b0}}};
        e_idx  = epos[E_SH +: IW];
        e_ov   = |epos[UW+IW-1:E_SH+IW];
        f4a    = fold_step(s3_frem_reg, thr_f, 4);
        f4b    = fold_step(f4a[AW-1:0], thr_f, 3);
    end

    logic signed [W-1:0]  s4_dry_reg;
    logic signed [YW-1:0] s4_y3_reg, s4_hard_reg, s4_crush_reg;
    logic                 s4_y3neg_reg, s4_y5pos_reg, s4_fsmall_reg;
    logic [31:0]          s4_t0_reg, s4_e0_reg, s4_e1_reg;
    logic signed [49:0]   s4_tprod_reg;
    logic [15:0]          s4_efr_reg;
    logic [AW-1:0]        s4_frem_reg;

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            s4_dry_reg    <= s3_dry_reg;
            s4_y3_reg     <= s3_y3_reg;
            s4_y3neg_reg  <= s3_y3neg_reg;
            s4_y5pos_reg  <= s3_y5pos_reg;
            s4_hard_reg   <= s3_hard_reg;
            s4_crush_reg  <= s3_crush_reg;
            s4_fsmall_reg <= s3_fsmall_reg;
            s4_t0_reg     <= s3_t0_reg;
            s4_tprod_reg  <= t_prod;
            s4_e0_reg     <= e_ov ? EXP_TAB[CURVE_DEPTH] : EXP_TAB[{1'b0, e_idx}];
            s4_e1_reg     <= e_ov ? EXP_TAB[CURVE_DEPTH]
                                  : EXP_TAB[{1'b0, e_idx} + (IW+1)'(1)];
            s4_efr_reg    <= epos[E_SH-1 -: 16];
            s4_frem_reg   <= f4b[AW-1:0];
        end
    end

    // Stage 5: tanh result, exp interpolation product, fold steps 2..1
    logic signed [49:0]   t_sum;
    logic [W-1:0]         t_val;
    logic signed [YW-1:0] t_val_s;
    logic signed [32:0]   e_diff;
    logic signed [49:0]   e_prod;
    logic [AW:0]          f5a, f5b;

    always_comb begin
        t_sum   = $signed({18'd0, s4_t0_reg}) + (s4_tprod_reg >>> 16);
        t_val   = t_sum[31-FRAC +: W];
        t_val_s = $signed(YW'(t_val));
        e_diff  = $signed({1'b0, s4_e1_reg}) - $signed({1'b0, s4_e0_reg});
        e_prod  = e_diff * $signed({1'b0, s4_efr_reg});
        f5a     = fold_step(s4_frem_reg, thr_f, 2);
        f5b     = fold_step(f5a[AW-1:0], thr_f, 1);
    end

    logic signed [W-1:0]  s5_dry_reg;
    logic signed [YW-1:0] s5_y3_reg, s5_hard_reg, s5_crush_reg, s5_soft_reg;
    logic                 s5_y3neg_reg, s5_y5pos_reg, s5_fsmall_reg;
    logic [31:0]          s5_e0_reg;
    logic signed [49:0]   s5_eprod_reg;
    logic [AW-1:0]        s5_frem_reg;

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            s5_dry_reg    <= s4_dry_reg;
            s5_y3_reg     <= s4_y3_reg;
            s5_y3neg_reg  <= s4_y3neg_reg;
            s5_y5pos_reg  <= s4_y5pos_reg;
            s5_hard_reg   <= s4_hard_reg;
            s5_crush_reg  <= s4_crush_reg;
            s5_fsmall_reg <= s4_fsmall_reg;
            s5_soft_reg   <= s4_y3neg_reg ? -t_val_s : t_val_s;
            s5_e0_reg     <= s4_e0_reg;
            s5_eprod_reg  <= e_prod;
            s5_frem_reg   <= f5b[AW-1:0];
        end
    end

    // Stage 6: waveshaper result, last fold step, mode select
    logic signed [49:0]   e_sum;
    logic [W-1:0]         e_val, w_mag;
    logic signed [YW-1:0] w_mag_s, wave_val, fold_val, rem_s, thr_f_s, wet_next;
    logic [AW:0]          f6;

    always_comb begin
        e_sum    = $signed({18'd0, s5_e0_reg}) + (s5_eprod_reg >>> 16);
        e_val    = e_sum[31-FRAC +: W];
        w_mag    = (W'(1) << FRAC) - e_val;
        w_mag_s  = $signed(YW'(w_mag));
        wave_val = s5_y5pos_reg ? w_mag_s : -w_mag_s;
        f6       = fold_step(s5_frem_reg, thr_f, 0);
        rem_s    = $signed(YW'(f6[AW-1:0]));
        thr_f_s  = $signed(YW'(thr_f));
        if (s5_fsmall_reg) begin
            fold_val = s5_y3_reg;
        end else if (f6[AW]) begin
            // odd fold count: reflect down from the next threshold multiple
            fold_val = thr_f_s - rem_s;
        end else begin
            fold_val = s5_y3neg_reg ? -rem_s : rem_s;
        end
        case (mode_reg)
            MODE_HARD:  wet_next = s5_hard_reg;
            MODE_FOLD:  wet_next = fold_val;
            MODE_WAVE:  wet_next = wave_val;
            MODE_CRUSH: wet_next = s5_crush_reg;
            default:    wet_next = s5_soft_reg;   // soft clip, also unused codes
        endcase
    end

    logic signed [W-1:0]  s6_dry_reg;
    logic signed [YW-1:0] s6_wet_reg;
    always_ff @(posedge aclk) begin
        if (adv[6]) begin
            s6_dry_reg <= s5_dry_reg;
            s6_wet_reg <= wet_next;
        end
    end

    // Stage 7: wet and dry weights
    logic signed [YW+13:0] s7_pw_reg;
    logic signed [W+13:0]  s7_pd_reg;
    always_ff @(posedge aclk) begin
        if (adv[7]) begin
            s7_pw_reg <= s6_wet_reg * $signed({1'b0, m_eff});
            s7_pd_reg <= s6_dry_reg * $signed({1'b0, m_inv});
        end
    end

    // Stage 8: mix sum and output gain
    logic signed [YW+14:0] mix_sum;
    logic signed [VW-1:0]  mix_val;
    logic signed [VW+14:0] s8_q_reg;
    always_comb begin
        mix_sum = s7_pw_reg + s7_pd_reg;
        mix_val = mix_sum[12 +: VW];
    end
    always_ff @(posedge aclk) begin
        if (adv[8]) begin
            s8_q_reg <= mix_val * $signed({1'b0, post_reg});
        end
    end

    // Stage 9: saturate into the output register
    logic signed [VW+2:0] q_sh;
    logic [W-1:0]         out_next, out_reg;
    always_comb begin
        q_sh = s8_q_reg[VW+14:12];
        if (q_sh > SAT_HI) begin
            out_next = SAT_HI[W-1:0];
        end else if (q_sh < SAT_LO) begin
            out_next = SAT_LO[W-1:0];
        end else begin
            out_next = q_sh[W-1:0];
        end
    end
    always_ff @(posedge aclk) begin
        if (adv[9]) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = TD_W'(out_reg);

`ifndef SYNTHESIS
    // no sample enters while thresholds are being recomputed
    a_no_input_during_thr: assert property (@(posedge aclk) disable iff (!aresetn)
        thr_busy |-> !in_fire)
        else $error("sample accepted while thresholds busy");

    // an accepted sample occupies the first stage on the next cycle
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> vld_reg[0])
        else $error("accepted sample lost at pipeline entry");

    // a stage that cannot move keeps its item and data
    a_hold_stage8: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[NSTG-2] && !adv[NSTG-1]) |=> (vld_reg[NSTG-2] && $stable(s8_q_reg)))
        else $error("stalled stage dropped or changed its item");
`endif

endmodule

### verif/tb_multimode_audio_distortion_top.sv
module tb_multimode_audio_distortion_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mad_pkg::*;

    localparam int SW = 24;
    localparam int BW = ((SW + 7) / 8) * 8;
    localparam int FRAC = SW - 1;
    localparam int PIPE_DEPTH = 10;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // Golden distortion chain: one expected output sample per accepted input sample.
    class distortion_scoreboard;
        longint drive, mix, pre, post, mode;
        longint exp_curve [0:CURVE_DEPTH];
        longint tanh_curve [0:CURVE_DEPTH];
        logic [SW-1:0] pending [$];
        int errors;

        function new();
            longint unsigned e;
            drive = 2048;
            mix = 2048;
            pre = 4096;
            post = 4096;
            mode = 0;
            errors = 0;
            for (int i = 0; i <= CURVE_DEPTH; i++) begin
                e = decay((longint'(i) << 35) / CURVE_DEPTH);
                exp_curve[i] = longint'(e);
                tanh_curve[i] = longint'((((64'd1 << 31) - e) << 31) / ((64'd1 << 31) + e));
            end
        endfunction

        // exp(-f), f in [0,1] Q.31, truncated alternating series
        function longint unsigned decay_frac(longint unsigned f);
            longint unsigned term;
            longint acc;
            term = 64'd1 << 31;
            acc = longint'(term);
            for (int k = 1; k <= 24; k++) begin
                term = ((term * f) >> 31) / longint'(k);
                if (k % 2 == 1) begin
                    acc -= longint'(term);
                end else begin
                    acc += longint'(term);
                end
            end
            return longint'(acc);
        endfunction

        function longint unsigned decay(longint unsigned t);
            longint unsigned whole, r, e1;
            whole = t >> 31;
            r = decay_frac(t & ((64'd1 << 31) - 1));
            e1 = decay_frac(64'd1 << 31);
            while (whole > 0) begin
                r = (r * e1) >> 31;
                whole--;
            end
            return r;
        endfunction

        // Interpolated curve read; u >= 0 in Q.FRAC, curve spans [0, 2^rb]
        function longint curve_read(bit use_tanh, longint u, int rb);
            longint unsigned pos, idx;
            longint fr, v, lo, hi;
            pos = longint'(u) * CURVE_DEPTH;
            idx = pos >> (FRAC + rb);
            if (idx >= CURVE_DEPTH) begin
                v = use_tanh ? tanh_curve[CURVE_DEPTH] : exp_curve[CURVE_DEPTH];
            end else begin
                fr = longint'((pos >> (FRAC + rb - 16)) & 64'hFFFF);
                lo = use_tanh ? tanh_curve[idx] : exp_curve[idx];
                hi = use_tanh ? tanh_curve[idx + 1] : exp_curve[idx + 1];
                v = lo + (((hi - lo) * fr) >>> 16);
            end
            return v >>> (31 - FRAC);
        endfunction

        function longint shape(longint x, longint d);
            longint k3, k5, y, a, thr, n, r, nbits, s;
            k3 = 4096 + 3 * d;
            k5 = 4096 + 5 * d;
            case (mode[2:0])
                MODE_HARD: begin
                    y = (x * k5) >>> 12;
                    thr = ((40960 - 9 * d) * (longint'(1) << FRAC)) / 40960;
                    if (y > thr) return thr;
                    if (y < -thr) return -thr;
                    return y;
                end
                MODE_FOLD: begin
                    y = (x * k3) >>> 12;
                    thr = (longint'(4096) << FRAC) / k3;
                    a = (y < 0) ? -y : y;
                    if (a <= thr) return y;
                    n = a / thr;
                    // even fold keeps the sign, odd fold reflects to positive
                    if (n % 2 == 0) return (y > 0) ? a - thr * n : -(a - thr * n);
                    return thr * (n + 1) - a;
                end
                MODE_WAVE: begin
                    y = (x * k5) >>> 12;
                    a = (y < 0) ? -y : y;
                    r = (longint'(1) << FRAC) - curve_read(1'b0, (a * k3) >>> 12, 4);
                    return (y > 0) ? r : -r;
                end
                MODE_CRUSH: begin
                    nbits = (16 * 4096 - 14 * d) / 4096;
                    if (nbits < 2) nbits = 2;
                    if (nbits > 16) nbits = 16;
                    s = FRAC - nbits;
                    y = (x * k3) >>> 12;
                    if (s <= 0) return y;
                    return (y >>> s) * (longint'(1) << s);
                end
                default: begin
                    // soft clip, unused modes included
                    y = (x * k3) >>> 12;
                    a = (y < 0) ? -y : y;
                    a = curve_read(1'b1, a, 3);
                    return (y < 0) ? -a : a;
                end
            endcase
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_DRIVE:     drive = val[12:0];
                REG_MIX:       mix = val[12:0];
                REG_PRE_GAIN:  pre = val;
                REG_POST_GAIN: post = val;
                REG_MODE:      mode = val[2:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic signed [SW-1:0] smp);
            longint dry, d, m, wet, v, top;
            dry = smp;
            d = (drive > 4096) ? 4096 : drive;
            m = (mix > 4096) ? 4096 : mix;
            top = (longint'(1) << FRAC) - 1;
            wet = shape((dry * pre) >>> 12, d);
            v = (wet * m + dry * (4096 - m)) >>> 12;
            v = (v * post) >>> 12;
            if (v > top) v = top;
            if (v < -top - 1) v = -top - 1;
            pending.push_back(v[SW-1:0]);
        endfunction

        function void check_result(logic [SW-1:0] got);
            logic [SW-1:0] want;
            if (pending.size() == 0) begin
                $display("%0t: out_sample with nothing pending: actual %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                $display("%0t: out_sample expected %h actual %h", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [BW-1:0] s_tdata = '0;     // in_sample
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [BW-1:0] m_tdata;          // out_sample

    distortion_scoreboard sb = new();

    bit quiet = 1'b0;        // no idling on either side once set
    int hold_cycles = 0;     // requested long receiver hold-off

    always #5 aclk = ~aclk;

    multimode_audio_distortion_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Check every output transfer against the oldest pending sample.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata[SW-1:0]);
        end
    end

    // Receiver backpressure: random stall bursts, plus a long hold-off on request.
    initial begin
        int burst;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready = 1'b0;
                repeat (hold_cycles) @(negedge aclk);
                hold_cycles = 0;
                m_tready = 1'b1;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 4);
                m_tready = 1'b0;
                repeat (burst - 1) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Offer one sample; hold tvalid high across back-to-back transfers.
    task automatic send_sample(logic signed [SW-1:0] smp);
        int gap;
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = BW'(smp);
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(smp);
    endtask

    // Drop tvalid, let every pending sample come back, then flush the pipeline.
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(cfg_reg_t'(idx), val);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic signed [SW-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(SW - 1){1'b0}}};
            1: return {1'b0, {(SW - 1){1'b1}}};
            2, 3: return SW'($signed($urandom_range(0, 131071)) - 65536);
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_q12(int top);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return CFG_DATA_W'(4096);
            2: return CFG_DATA_W'(top);
            default: return CFG_DATA_W'($urandom_range(0, 4096));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return CFG_DATA_W'(1029);
            1: return CFG_DATA_W'(16306);
            2: return '0;
            3: return CFG_DATA_W'(16383);
            default: return CFG_DATA_W'($urandom_range(1029, 16306));
        endcase
    endfunction

    initial begin
        logic signed [SW-1:0] edge_vals [6];
        edge_vals = '{24'sh800000, 24'sh7FFFFF, 24'sh000000, -24'sd1, 24'sd1, 24'sh400000};

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset settings, full-scale and zero samples.
        foreach (edge_vals[i]) send_sample(edge_vals[i]);
        drain();

        // Each curve (and the spare mode codes) at full drive, fully wet, hot gains.
        write_reg(REG_DRIVE, 14'd8191);   // drive above one clamps
        write_reg(REG_MIX, 14'd8191);     // mix above one clamps
        write_reg(REG_PRE_GAIN, 14'd16306);
        write_reg(REG_POST_GAIN, 14'd16306);
        write_reg(REG_SPARE_LO, 14'h3FFF); // unknown index: ignored
        write_reg(REG_SPARE_HI, 14'h0001);
        for (int md = MODE_SOFT; md <= 7; md++) begin
            write_reg(REG_MODE, CFG_DATA_W'(md));
            send_sample(24'sh7FFFFF);
            send_sample(24'sh800000);
            send_sample(24'sh0C0000);
            drain();
        end
        drain();

        // Zero gain gives silence; zero drive gives the finest bitcrush.
        write_reg(REG_PRE_GAIN, 14'd0);
        write_reg(REG_DRIVE, 14'd0);
        write_reg(REG_MODE, CFG_DATA_W'(MODE_CRUSH));
        send_sample(24'sh123456);
        drain();
        write_reg(REG_PRE_GAIN, 14'd4096);
        send_sample(-24'sd12345);
        drain();

        // Random phases: fresh settings each time, then a run of samples.
        for (int ph = 0; ph < 11; ph++) begin
            write_reg(REG_DRIVE, pick_q12(8191));
            write_reg(REG_MIX, pick_q12(8191));
            write_reg(REG_PRE_GAIN, pick_gain());
            write_reg(REG_POST_GAIN, pick_gain());
            write_reg(REG_MODE, CFG_DATA_W'($urandom_range(0, 9) < 8 ?
                                             $urandom_range(0, 4) : $urandom_range(5, 7)));
            if (ph == 10) quiet = 1'b1;
            for (int n = 0; n < 100; n++) begin
                if (ph == 3 && n == 10) hold_cycles = 60;   // back the pipeline up
                if (ph == 6 && n == 50) drain();            // sender pauses until empty
                send_sample(pick_sample());
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
